/* src/vid_pkg.sv */
// Shared types, codes and default sizes of the vertex index dedup block.
package vid_pkg;

    localparam int MAX_UNIQUE_DEF = 256;
    localparam int INDEX_BITS_DEF = 16;
    localparam int FIELD_W        = 16;
    localparam int SLOT_OUT_W     = 8;
    localparam int STATUS_W       = 3;
    localparam int CFG_IDX_W      = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXCOORD_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_COUNT   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_POS = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_TEX = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_NRM = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd4;

    typedef struct packed {
        logic               restart;
        logic [FIELD_W-1:0] position_ref;
        logic [FIELD_W-1:0] texcoord_ref;
        logic [FIELD_W-1:0] normal_ref;
    } t_corner;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] vertex_slot;
        logic                  is_new;
        logic [STATUS_W-1:0]   status;
    } t_result;

    // Lookup token control that walks the cell chain
    typedef struct packed {
        logic active;
        logic found;
    } t_probe_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_SEARCH
    } t_state;

endpackage

/* src/vid_cell.sv */
// One table slot of the dedup chain: stored triple plus one stage of the lookup token.
module vid_cell #(
    parameter int INDEX_BITS = 16,
    parameter int SLOT_W     = 8,
    parameter int CNT_W      = 9,
    parameter int CELL_IDX   = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  vid_pkg::t_probe_ctl     i_ctl,
    input  logic [3*INDEX_BITS-1:0] i_key,
    input  logic [SLOT_W-1:0]       i_slot,
    input  logic [CNT_W-1:0]        i_count,
    input  logic                    i_wr_en,
    input  logic [SLOT_W-1:0]       i_wr_addr,
    input  logic [3*INDEX_BITS-1:0] i_wr_key,
    output vid_pkg::t_probe_ctl     o_ctl,
    output logic [3*INDEX_BITS-1:0] o_key,
    output logic [SLOT_W-1:0]       o_slot
);
    import vid_pkg::*;

    logic [3*INDEX_BITS-1:0] r_entry;
    t_probe_ctl              r_ctl;
    t_probe_ctl              n_ctl;
    logic [3*INDEX_BITS-1:0] r_key;
    logic [SLOT_W-1:0]       r_slot;
    logic [SLOT_W-1:0]       n_slot;
    logic                    hit;

    // Only slots below the fill count hold live triples
    assign hit = i_ctl.active && !i_ctl.found
                 && (CNT_W'(CELL_IDX) < i_count) && (r_entry == i_key);

    always_comb begin
        n_ctl  = i_ctl;
        n_slot = i_slot;
        if (hit) begin
            n_ctl.found = 1'b1;
            n_slot      = SLOT_W'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= i_key;
        r_slot <= n_slot;
        if (i_wr_en && (i_wr_addr == SLOT_W'(CELL_IDX))) begin
            r_entry <= i_wr_key;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_key  = r_key;
    assign o_slot = r_slot;

endmodule

/* src/vid_chain.sv */
// Row of dedup cells; the lookup token enters at cell 0 and leaves at the last cell.
module vid_chain #(
    parameter int MAX_UNIQUE = 256,
    parameter int INDEX_BITS = 16,
    parameter int SLOT_W     = 8,
    parameter int CNT_W      = 9
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  vid_pkg::t_probe_ctl     i_ctl,
    input  logic [3*INDEX_BITS-1:0] i_key,
    input  logic [CNT_W-1:0]        i_count,
    input  logic                    i_wr_en,
    input  logic [SLOT_W-1:0]       i_wr_addr,
    output vid_pkg::t_probe_ctl     o_ctl,
    output logic [SLOT_W-1:0]       o_slot
);
    import vid_pkg::*;

    t_probe_ctl              ctl_link  [MAX_UNIQUE+1];
    logic [3*INDEX_BITS-1:0] key_link  [MAX_UNIQUE+1];
    logic [SLOT_W-1:0]       slot_link [MAX_UNIQUE+1];

    assign ctl_link[0]  = i_ctl;
    assign key_link[0]  = i_key;
    assign slot_link[0] = '0;

    for (genvar g = 0; g < MAX_UNIQUE; g++) begin : g_cell
        vid_cell #(
            .INDEX_BITS (INDEX_BITS),
            .SLOT_W     (SLOT_W),
            .CNT_W      (CNT_W),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl_link[g]),
            .i_key     (key_link[g]),
            .i_slot    (slot_link[g]),
            .i_count   (i_count),
            .i_wr_en   (i_wr_en),
            .i_wr_addr (i_wr_addr),
            .i_wr_key  (i_key),
            .o_ctl     (ctl_link[g+1]),
            .o_key     (key_link[g+1]),
            .o_slot    (slot_link[g+1])
        );
    end

    assign o_ctl  = ctl_link[MAX_UNIQUE];
    assign o_slot = slot_link[MAX_UNIQUE];

endmodule

/* src/vertex_index_dedup.sv */
// Top level of the vertex index dedup block: range checks, control and the cell chain.
//
// Usage:
// - Command channel: drive start with a corner on i_item; the corner is taken at a
//   rising edge where start is high and busy is low. restart in the corner empties
//   the table of unique triples before that corner is handled.
// - Result channel: o_result_valid strobes for exactly one cycle with o_result.
//   The receiver cannot stall; it must take the result in that cycle.
// - Configuration channel: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data.
//   o_cfg_ready is always high; write only while no corner is in flight.
//   Indexes past the normal count are ignored.
// - Timing: a rejected corner (bad reference) shows its result in the cycle right
//   after acceptance. A corner that passes its checks walks a lookup token through
//   the MAX_UNIQUE cells, one cell per cycle, and shows its result once the token
//   leaves the last cell and the result register takes it. busy drops in the cycle
//   the result is shown, so the next corner can be taken then; a new corner is not
//   taken while one is being searched. The cell chain length sets the search time.
// - Reset (synchronous, active low): counts go to zero, the table is empty, no
//   result is pending. Table contents need no clearing; the fill count guards them.
module vertex_index_dedup #(
    parameter int MAX_UNIQUE = vid_pkg::MAX_UNIQUE_DEF,
    parameter int INDEX_BITS = vid_pkg::INDEX_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  vid_pkg::t_corner               i_item,
    output logic                           o_result_valid,
    output vid_pkg::t_result               o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [vid_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vid_pkg::FIELD_W-1:0]    i_cfg_data
);
    import vid_pkg::*;

    localparam int SLOT_W = $clog2(MAX_UNIQUE);
    localparam int CNT_W  = $clog2(MAX_UNIQUE + 1);

    // Configuration registers, taken modulo 2^INDEX_BITS
    logic [INDEX_BITS-1:0] r_pos_count;
    logic [INDEX_BITS-1:0] r_tex_count;
    logic [INDEX_BITS-1:0] r_nrm_count;
    logic [INDEX_BITS-1:0] cfg_value;

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_count;
    logic [3*INDEX_BITS-1:0] r_key;
    logic                  r_out_valid;
    t_result               r_result;

    logic [INDEX_BITS-1:0] in_pos;
    logic [INDEX_BITS-1:0] in_tex;
    logic [INDEX_BITS-1:0] in_nrm;
    logic [STATUS_W-1:0]   check_status;
    logic                  accept;
    logic                  launch;
    logic                  resolve;
    logic                  table_full;
    logic                  wr_en;
    t_probe_ctl            head_ctl;
    t_probe_ctl            tail_ctl;
    logic [SLOT_W-1:0]     tail_slot;

    // Configuration writes: always ready
    assign o_cfg_ready = 1'b1;
    assign cfg_value   = INDEX_BITS'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_count <= '0;
            r_tex_count <= '0;
            r_nrm_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_POSITION_COUNT: r_pos_count <= cfg_value;
                CFG_TEXCOORD_COUNT: r_tex_count <= cfg_value;
                CFG_NORMAL_COUNT:   r_nrm_count <= cfg_value;
                default:            ;
            endcase
        end
    end

    // Range checks on the incoming corner: position first, then texcoord and
    // normal only when their count is nonzero. The first failure wins.
    assign in_pos = INDEX_BITS'(i_item.position_ref);
    assign in_tex = INDEX_BITS'(i_item.texcoord_ref);
    assign in_nrm = INDEX_BITS'(i_item.normal_ref);

    always_comb begin
        check_status = STATUS_OK;
        if (in_pos == '0 || in_pos > r_pos_count) begin
            check_status = STATUS_BAD_POS;
        end else if (r_tex_count != '0 && (in_tex == '0 || in_tex > r_tex_count)) begin
            check_status = STATUS_BAD_TEX;
        end else if (r_nrm_count != '0 && (in_nrm == '0 || in_nrm > r_nrm_count)) begin
            check_status = STATUS_BAD_NRM;
        end
    end

    // Control outputs
    always_comb begin
        busy    = (r_state != S_IDLE);
        accept  = start && (r_state == S_IDLE);
        launch  = (r_state == S_LAUNCH);
        resolve = (r_state == S_SEARCH) && tail_ctl.active;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && check_status == STATUS_OK) begin
                    n_state = S_LAUNCH;
                end
            end
            S_LAUNCH: begin
                n_state = S_SEARCH;
            end
            S_SEARCH: begin
                if (tail_ctl.active) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A miss with every slot in use reports a full table and stores nothing
    assign table_full = (r_count == CNT_W'(MAX_UNIQUE));
    assign wr_en      = resolve && !tail_ctl.found && !table_full;

    // Fill count and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            if (accept) begin
                // Restart empties the table even for a rejected corner
                if (i_item.restart) begin
                    r_count <= '0;
                end
                if (check_status != STATUS_OK) begin
                    r_out_valid <= 1'b1;
                end
            end
            if (resolve) begin
                r_out_valid <= 1'b1;
                if (wr_en) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    // Result payload and held lookup key
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= {in_pos, in_tex, in_nrm};
            r_result.vertex_slot <= '0;
            r_result.is_new      <= 1'b0;
            r_result.status      <= check_status;
        end
        if (resolve) begin
            if (tail_ctl.found) begin
                r_result.vertex_slot <= SLOT_OUT_W'(tail_slot);
                r_result.is_new      <= 1'b0;
                r_result.status      <= STATUS_OK;
            end else if (table_full) begin
                r_result.vertex_slot <= '0;
                r_result.is_new      <= 1'b0;
                r_result.status      <= STATUS_FULL;
            end else begin
                r_result.vertex_slot <= SLOT_OUT_W'(r_count);
                r_result.is_new      <= 1'b1;
                r_result.status      <= STATUS_OK;
            end
        end
    end

    // Inject the lookup token for one cycle; the chain compares it against
    // each live slot as it advances and keeps the first match.
    assign head_ctl.active = launch;
    assign head_ctl.found  = 1'b0;

    vid_chain #(
        .MAX_UNIQUE (MAX_UNIQUE),
        .INDEX_BITS (INDEX_BITS),
        .SLOT_W     (SLOT_W),
        .CNT_W      (CNT_W)
    ) u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (head_ctl),
        .i_key     (r_key),
        .i_count   (r_count),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[SLOT_W-1:0]),
        .o_ctl     (tail_ctl),
        .o_slot    (tail_slot)
    );

    assign o_result_valid = r_out_valid;
    assign o_result       = r_result;

endmodule

/* src/vid_checker.sv */
// Port-level checks of the vertex index dedup block, bound to the top level.
module vid_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_result_valid,
    input vid_pkg::t_result o_result
);
    import vid_pkg::*;

    // A result only shows once the block is free for the next corner
    a_result_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted corner either starts a lookup or reports a rejection next cycle
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_result_valid))
        else $error("accepted corner made no progress");

    // Only a clean corner can append a triple
    a_new_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.is_new) |-> (o_result.status == STATUS_OK))
        else $error("new triple with bad status");

    // A failed corner reports slot zero and no append
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status != STATUS_OK)
            |-> (o_result.vertex_slot == '0 && !o_result.is_new))
        else $error("failed corner carries a slot or append");

endmodule

bind vertex_index_dedup vid_checker u_vid_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

/* sim/tb_top.sv */
// Testbench of vertex_index_dedup: directed and random corner streams checked against a predictor.
module tb_top;
    import vid_pkg::*;

    localparam int SLOTS = MAX_UNIQUE_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [FIELD_W-1:0] p;
        logic [FIELD_W-1:0] t;
        logic [FIELD_W-1:0] n;
    } t_triple;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_corner              i_item = '0;
    logic                 o_result_valid;
    t_result              o_result;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [FIELD_W-1:0]   i_cfg_data = '0;

    // Predictor state: the counts and the table of distinct triples
    logic [FIELD_W-1:0] pos_limit = '0;
    logic [FIELD_W-1:0] tex_limit = '0;
    logic [FIELD_W-1:0] nrm_limit = '0;
    t_triple            seen_triples [SLOTS];
    int                 seen_count = 0;

    t_result expected_lookups [$];
    int      fault_count = 0;
    bit      no_idle = 1'b0;

    vertex_index_dedup i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #60_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic bit out_of_range(logic [FIELD_W-1:0] ref_val, logic [FIELD_W-1:0] count);
        return ref_val == '0 || ref_val > count;
    endfunction

    // Range-check one corner, then find or append its triple
    function automatic t_result dedup_corner(t_corner c);
        t_result     r;
        t_triple     key;
        bit          hit;
        r   = '0;
        hit = 1'b0;
        key = '{c.position_ref, c.texcoord_ref, c.normal_ref};
        if (c.restart) begin
            seen_count = 0;
        end
        if (out_of_range(c.position_ref, pos_limit)) begin
            r.status = STATUS_BAD_POS;
        end else if (tex_limit != '0 && out_of_range(c.texcoord_ref, tex_limit)) begin
            r.status = STATUS_BAD_TEX;
        end else if (nrm_limit != '0 && out_of_range(c.normal_ref, nrm_limit)) begin
            r.status = STATUS_BAD_NRM;
        end else begin
            r.status = STATUS_OK;
        end
        if (r.status == STATUS_OK) begin
            for (int k = 0; k < seen_count; k++) begin
                if (!hit && seen_triples[k] == key) begin
                    r.vertex_slot = SLOT_OUT_W'(k);
                    hit = 1'b1;
                end
            end
            if (!hit) begin
                if (seen_count >= SLOTS) begin
                    r.status = STATUS_FULL;
                end else begin
                    r.vertex_slot = SLOT_OUT_W'(seen_count);
                    r.is_new = 1'b1;
                    seen_triples[seen_count] = key;
                    seen_count++;
                end
            end
        end
        return r;
    endfunction

    function automatic t_corner corner_of(logic rs, logic [FIELD_W-1:0] p,
                                          logic [FIELD_W-1:0] t, logic [FIELD_W-1:0] n);
        t_corner c;
        c.restart      = rs;
        c.position_ref = p;
        c.texcoord_ref = t;
        c.normal_ref   = n;
        return c;
    endfunction

    // A reference that passes its check; any value when the check is off
    function automatic logic [FIELD_W-1:0] ref_within(logic [FIELD_W-1:0] count);
        if (count == '0) begin
            return FIELD_W'($urandom);
        end
        return FIELD_W'($urandom_range(1, count));
    endfunction

    function automatic logic [FIELD_W-1:0] pick_count();
        int roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0: return '0;
            1: return 16'd1;
            2: return 16'hFFFF;
            3, 4, 5, 6: return FIELD_W'($urandom_range(1, 24));
            default: return FIELD_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic report_fault(string what, t_result want, t_result got);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%s: expected slot %0d new %0b status %0d, got slot %0d new %0b status %0d",
                     what, want.vertex_slot, want.is_new, want.status,
                     got.vertex_slot, got.is_new, got.status);
        end
    endtask

    // Compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_result_valid) begin
            if (expected_lookups.size() == 0) begin
                report_fault("unexpected result", '0, o_result);
            end else begin
                want = expected_lookups.pop_front();
                if (o_result.vertex_slot !== want.vertex_slot || o_result.is_new !== want.is_new
                    || o_result.status !== want.status) begin
                    report_fault("result mismatch", want, o_result);
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_POSITION_COUNT: pos_limit = val;
            CFG_TEXCOORD_COUNT: tex_limit = val;
            CFG_NORMAL_COUNT:   nrm_limit = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_counts(logic [FIELD_W-1:0] p, logic [FIELD_W-1:0] t,
                                logic [FIELD_W-1:0] n);
        write_reg(CFG_POSITION_COUNT, p);
        write_reg(CFG_TEXCOORD_COUNT, t);
        write_reg(CFG_NORMAL_COUNT, n);
    endtask

    // Hold start high across back-to-back corners; drop it only for a pause
    task automatic send_corner(t_corner c);
        int      gap;
        t_result want;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            start <= 1'b0;
            if ($urandom_range(0, 1) == 1) begin
                // count the pause from the cycle the block is free again
                do @(posedge i_clk); while (busy);
                gap--;
            end
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        want = dedup_corner(c);
        expected_lookups = {expected_lookups, want};
    endtask

    // Drop start, let every result arrive, then allow one full search of slack
    task automatic wait_for_results();
        start <= 1'b0;
        while (expected_lookups.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 4) @(posedge i_clk);
    endtask

    // With all counts at zero every position is out of range
    task automatic test_reset_counts();
        send_corner(corner_of(1'b1, 16'd1, 16'd1, 16'd1));
        send_corner(corner_of(1'b0, 16'hFFFF, 16'd0, 16'd0));
        wait_for_results();
    endtask

    task automatic test_range_checks();
        write_counts(16'd10, 16'd0, 16'd0);
        write_reg(CFG_UNUSED, 16'd5);
        // texcoord and normal checks are off
        send_corner(corner_of(1'b0, 16'd10, 16'hFFFF, 16'hFFFF));
        send_corner(corner_of(1'b0, 16'd10, 16'd0, 16'd0));
        send_corner(corner_of(1'b0, 16'd10, 16'hFFFF, 16'hFFFF));
        wait_for_results();
        write_reg(CFG_TEXCOORD_COUNT, 16'd5);
        write_reg(CFG_NORMAL_COUNT, 16'd7);
        send_corner(corner_of(1'b0, 16'd0, 16'd1, 16'd1));
        // position wins over a bad texcoord
        send_corner(corner_of(1'b0, 16'd11, 16'd9, 16'd0));
        send_corner(corner_of(1'b0, 16'd3, 16'd0, 16'd1));
        send_corner(corner_of(1'b0, 16'd3, 16'd6, 16'd1));
        send_corner(corner_of(1'b0, 16'd3, 16'd5, 16'd0));
        send_corner(corner_of(1'b0, 16'd3, 16'd5, 16'd8));
        send_corner(corner_of(1'b0, 16'd1, 16'd1, 16'd1));
        // a rejected corner still empties the table on restart
        send_corner(corner_of(1'b1, 16'd0, 16'd1, 16'd1));
        send_corner(corner_of(1'b0, 16'd1, 16'd1, 16'd1));
        wait_for_results();
    endtask

    task automatic test_extremes();
        write_counts(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_corner(corner_of(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_corner(corner_of(1'b0, 16'd1, 16'd1, 16'd1));
        send_corner(corner_of(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_corner(corner_of(1'b0, 16'hFFFF, 16'd0, 16'd1));
        send_corner(corner_of(1'b0, 16'd1, 16'd1, 16'd0));
        wait_for_results();
        write_reg(CFG_POSITION_COUNT, 16'd1);
        send_corner(corner_of(1'b0, 16'd2, 16'd1, 16'd1));
        send_corner(corner_of(1'b0, 16'd1, 16'd1, 16'd1));
        wait_for_results();
    endtask

    // Fill every slot, then overflow, hit both ends and recover by restart
    task automatic test_table_full();
        t_triple stored [SLOTS];
        t_triple extra;
        write_counts(16'hFFFF, 16'hFFFF, 16'd0);
        no_idle = 1'b1;
        for (int k = 0; k < SLOTS; k++) begin
            if (k == SLOTS / 2) begin
                no_idle = 1'b0;
            end
            stored[k] = '{FIELD_W'(k + 1), ref_within(tex_limit), ref_within(16'd0)};
            send_corner(corner_of(k == 0, stored[k].p, stored[k].t, stored[k].n));
        end
        extra = '{FIELD_W'(SLOTS + 1), ref_within(tex_limit), ref_within(16'd0)};
        send_corner(corner_of(1'b0, extra.p, extra.t, extra.n));
        send_corner(corner_of(1'b0, 16'd0, extra.t, extra.n));
        send_corner(corner_of(1'b0, stored[SLOTS-1].p, stored[SLOTS-1].t, stored[SLOTS-1].n));
        send_corner(corner_of(1'b0, stored[0].p, stored[0].t, stored[0].n));
        send_corner(corner_of(1'b0, extra.p, extra.t, extra.n));
        send_corner(corner_of(1'b1, extra.p, extra.t, extra.n));
        send_corner(corner_of(1'b0, stored[0].p, stored[0].t, stored[0].n));
        wait_for_results();
    endtask

    // Phases of random counts; corners mostly reuse a small pool so lookups hit
    task automatic test_random_stream();
        t_triple pool [$];
        t_triple pick;
        logic [FIELD_W-1:0] bad_ref;
        int roll;
        int pool_len;
        for (int ph = 0; ph < 10; ph++) begin
            wait_for_results();
            write_reg(CFG_POSITION_COUNT, pick_count());
            if (pos_limit == '0 && $urandom_range(0, 3) != 0) begin
                write_reg(CFG_POSITION_COUNT, 16'd8);
            end
            write_reg(CFG_TEXCOORD_COUNT, pick_count());
            write_reg(CFG_NORMAL_COUNT, pick_count());
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_UNUSED, FIELD_W'($urandom));
            end
            pool.delete();
            pool_len = $urandom_range(1, 30);
            repeat (pool_len) begin
                pick = '{ref_within(pos_limit), ref_within(tex_limit), ref_within(nrm_limit)};
                pool = {pool, pick};
            end
            for (int i = 0; i < 80; i++) begin
                if ($urandom_range(0, 39) == 0) begin
                    no_idle = !no_idle;
                end
                roll = $urandom_range(0, 99);
                pick = pool[$urandom_range(0, pool.size() - 1)];
                if (roll >= 92) begin
                    pick = '{FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom)};
                end else if (roll >= 80) begin
                    // break one reference: zero or one past its count
                    case ($urandom_range(0, 2))
                        0: begin
                            bad_ref = $urandom_range(0, 1) ? '0 : pos_limit + 16'd1;
                            pick.p = bad_ref;
                        end
                        1: begin
                            bad_ref = $urandom_range(0, 1) ? '0 : tex_limit + 16'd1;
                            pick.t = bad_ref;
                        end
                        default: begin
                            bad_ref = $urandom_range(0, 1) ? '0 : nrm_limit + 16'd1;
                            pick.n = bad_ref;
                        end
                    endcase
                end
                send_corner(corner_of($urandom_range(0, 39) == 0, pick.p, pick.t, pick.n));
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_counts();
        test_range_checks();
        test_extremes();
        test_table_full();
        test_random_stream();
        wait_for_results();
        if (fault_count == 0 && expected_lookups.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
